[design/m3inv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared constants and types for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int THR_WIDTH         = 31;
    localparam int THR_RESET         = 1;
    localparam int NUM_ELEM          = 9;

    // per-lane status out of the divider
    typedef struct packed {
        logic [NUM_ELEM-1:0] ovf;
        logic [NUM_ELEM-1:0] neg;
    } t_div_flags;

endpackage

[design/m3inv_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv interfaces
// Matrix request, inverse result and threshold write channels.
// ----------------------------------------------------------------------------
interface m3inv_mat_if #(parameter int ELEMENT_WIDTH = m3inv_pkg::ELEMENT_WIDTH_DEF);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] a11, a12, a13;
    logic signed [ELEMENT_WIDTH-1:0] a21, a22, a23;
    logic signed [ELEMENT_WIDTH-1:0] a31, a32, a33;

    modport source (output valid, a11, a12, a13, a21, a22, a23, a31, a32, a33,
                    input ready);
    modport sink   (input valid, a11, a12, a13, a21, a22, a23, a31, a32, a33,
                    output ready);
endinterface

interface m3inv_res_if #(parameter int ELEMENT_WIDTH = m3inv_pkg::ELEMENT_WIDTH_DEF);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] r11, r12, r13;
    logic signed [ELEMENT_WIDTH-1:0] r21, r22, r23;
    logic signed [ELEMENT_WIDTH-1:0] r31, r32, r33;
    logic signed [ELEMENT_WIDTH-1:0] det_value;
    logic                            singular;
    logic                            saturated;

    modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    det_value, singular, saturated, input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    det_value, singular, saturated, output ready);
endinterface

interface m3inv_cfg_if;
    import m3inv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [THR_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[design/matrix3x3_inverse_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Fully pipelined 3x3 fixed-point matrix inverse by the adjugate method.
// ----------------------------------------------------------------------------
// Usage:
//  - i_mat carries one request per matrix: nine signed fixed-point elements,
//    row by row. o_inv returns the inverse, the rounded determinant and the
//    singular / saturated flags. i_cfg writes the singular threshold
//    (always ready, write only while the core is idle).
//  - Throughput: one matrix per cycle while o_inv is not stalled. The
//    divider resolves one quotient bit per stage for all nine elements in
//    parallel.
//  - Stages: products, cofactors, partial products, full products,
//    determinant, magnitudes, divider entry, ELEMENT_WIDTH quotient stages,
//    rounding, clipping into the output register.
//  - A stall on o_inv freezes the whole pipeline in place and drops i_mat
//    ready in the same cycle; nothing is lost or repeated.
//  - Reset clears all valid bits and loads the threshold with its reset
//    value of one LSB.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core #(
    parameter int ELEMENT_WIDTH = m3inv_pkg::ELEMENT_WIDTH_DEF,
    parameter int FRACTION_BITS = m3inv_pkg::FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    m3inv_mat_if.sink  i_mat,
    m3inv_cfg_if.sink  i_cfg,
    m3inv_res_if.source o_inv
);
    import m3inv_pkg::*;

    localparam int W  = ELEMENT_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int CW = 2 * W + 1;          // cofactor, signed
    localparam int DW = 3 * W + 3;          // determinant, signed
    localparam int NW = CW + 2 * F;         // scaled adjugate magnitude
    localparam int TW = DW + 2;             // {singular, det sign, det magnitude}
    localparam int SW = DW + THR_WIDTH + 2 * F;

    localparam logic [W:0]  LIM  = (W+1)'(1) << (W - 1);
    localparam logic [DW-1:0] LIMD = DW'(1) << (W - 1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // global advance: pipeline moves whenever the output slot is empty or its result is taken
    logic w_en;
    logic r_ovld;
    assign w_en = !r_ovld || o_inv.ready;

    // threshold register
    logic [THR_WIDTH-1:0] r_thr;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_WIDTH'(THR_RESET);
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    logic signed [W-1:0] w_a [3][3];
    always_comb begin
        w_a[0][0] = i_mat.a11; w_a[0][1] = i_mat.a12; w_a[0][2] = i_mat.a13;
        w_a[1][0] = i_mat.a21; w_a[1][1] = i_mat.a22; w_a[1][2] = i_mat.a23;
        w_a[2][0] = i_mat.a31; w_a[2][1] = i_mat.a32; w_a[2][2] = i_mat.a33;
    end
    assign i_mat.ready = w_en;

    logic [5:0] r_vld;     // stages 1..6
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[4:0], i_mat.valid};
        end
    end

    // stage 1: the 18 two-element products of the cofactors
    logic signed [2*W-1:0] r_p1 [3][3];
    logic signed [2*W-1:0] r_p2 [3][3];
    logic signed [W-1:0]   r_a1 [3];
    // stage 2: signed cofactors (cyclic index order gives the sign)
    logic signed [CW-1:0]  r_c2 [3][3];
    logic signed [W-1:0]   r_a2 [3];
    // stage 3: first row times first-row cofactors, split in halves
    logic signed [2*W:0]   r_plo [3];
    logic signed [2*W:0]   r_phi [3];
    logic signed [CW-1:0]  r_c3 [3][3];
    // stage 4: full products
    logic signed [DW-1:0]  r_prod [3];
    logic signed [CW-1:0]  r_c4 [3][3];
    // stage 5: determinant
    logic signed [DW-1:0]  r_det;
    logic signed [CW-1:0]  r_c5 [3][3];
    // stage 6: magnitudes and signs
    logic [DW-1:0]         r_adet;
    logic                  r_dneg;
    logic [NW-1:0]         r_num [NUM_ELEM];
    logic [NUM_ELEM-1:0]   r_lneg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p1[i][j] <= w_a[(i+1)%3][(j+1)%3] * w_a[(i+2)%3][(j+2)%3];
                    r_p2[i][j] <= w_a[(i+1)%3][(j+2)%3] * w_a[(i+2)%3][(j+1)%3];
                    r_c2[i][j] <= CW'(r_p1[i][j]) - CW'(r_p2[i][j]);
                    r_c3[i][j] <= r_c2[i][j];
                    r_c4[i][j] <= r_c3[i][j];
                    r_c5[i][j] <= r_c4[i][j];
                end
            end
            for (int j = 0; j < 3; j++) begin
                r_a1[j]   <= w_a[0][j];
                r_a2[j]   <= r_a1[j];
                r_plo[j]  <= r_a2[j] * $signed({1'b0, r_c2[0][j][W-1:0]});
                r_phi[j]  <= r_a2[j] * $signed(r_c2[0][j][CW-1:W]);
                r_prod[j] <= (DW'(r_phi[j]) <<< W) + DW'(r_plo[j]);
            end
            r_det  <= r_prod[0] + r_prod[1] + r_prod[2];
            r_dneg <= r_det[DW-1];
            r_adet <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            // inverse (i,j) takes adjugate entry = cofactor (j,i)
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_num[i*3+j]  <= {(r_c5[j][i][CW-1] ? CW'(-r_c5[j][i])
                                                        : CW'(r_c5[j][i])),
                                      {(2*F){1'b0}}};
                    r_lneg[i*3+j] <= r_c5[j][i][CW-1] ^ r_det[DW-1];
                end
            end
        end
    end

    // singular test and determinant rounding beside the divider entry
    logic          w_sing;
    logic [DW-1:0] w_dvmag;
    assign w_sing  = (r_adet == '0) || (SW'(r_adet) < (SW'(r_thr) << (2 * F)));
    assign w_dvmag = (r_adet >> (2 * F)) + DW'(r_adet[2*F-1]);

    logic                 w_dvalid;
    logic [W:0]           w_quo [NUM_ELEM];
    t_div_flags           w_flags;
    logic [TW-1:0]        w_tag;

    m3inv_div #(
        .W  (W),
        .NW (NW),
        .DW (DW),
        .TW (TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld[5]),
        .i_num   (r_num),
        .i_neg   (r_lneg),
        .i_den   (r_adet),
        .i_tag   ({w_sing, r_dneg, w_dvmag}),
        .o_valid (w_dvalid),
        .o_quo   (w_quo),
        .o_flags (w_flags),
        .o_tag   (w_tag)
    );

    // clipping to the element range
    logic                w_tsing;
    logic                w_tdneg;
    logic [DW-1:0]       w_tmag;
    logic [W-1:0]        w_res [NUM_ELEM];
    logic [NUM_ELEM-1:0] w_lsat;
    logic [W-1:0]        w_det;
    logic                w_dsat;
    logic [W:0]          w_nq;
    logic [DW-1:0]       w_nd;

    assign w_tsing = w_tag[TW-1];
    assign w_tdneg = w_tag[TW-2];
    assign w_tmag  = w_tag[DW-1:0];

    always_comb begin
        w_nq = '0;
        for (int l = 0; l < NUM_ELEM; l++) begin
            w_nq = -w_quo[l];
            w_lsat[l] = 1'b0;
            if (w_flags.ovf[l] || (!w_flags.neg[l] && (w_quo[l] >= LIM))
                               || (w_flags.neg[l] && (w_quo[l] > LIM))) begin
                w_lsat[l] = 1'b1;
                w_res[l]  = w_flags.neg[l] ? MINV : MAXV;
            end else begin
                w_res[l]  = w_flags.neg[l] ? w_nq[W-1:0] : w_quo[l][W-1:0];
            end
            if (w_tsing) begin
                w_res[l]  = '0;
                w_lsat[l] = 1'b0;
            end
        end
        w_nd = -w_tmag;
        if ((!w_tdneg && (w_tmag >= LIMD)) || (w_tdneg && (w_tmag > LIMD))) begin
            w_dsat = 1'b1;
            w_det  = w_tdneg ? MINV : MAXV;
        end else begin
            w_dsat = 1'b0;
            w_det  = w_tdneg ? w_nd[W-1:0] : w_tmag[W-1:0];
        end
    end

    // output register
    logic [W-1:0] r_res [NUM_ELEM];
    logic [W-1:0] r_det_o;
    logic         r_sing;
    logic         r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_dvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res   <= w_res;
            r_det_o <= w_det;
            r_sing  <= w_tsing;
            r_sat   <= w_dsat || (|w_lsat);
        end
    end

    assign o_inv.valid     = r_ovld;
    assign o_inv.r11       = r_res[0];
    assign o_inv.r12       = r_res[1];
    assign o_inv.r13       = r_res[2];
    assign o_inv.r21       = r_res[3];
    assign o_inv.r22       = r_res[4];
    assign o_inv.r23       = r_res[5];
    assign o_inv.r31       = r_res[6];
    assign o_inv.r32       = r_res[7];
    assign o_inv.r33       = r_res[8];
    assign o_inv.det_value = r_det_o;
    assign o_inv.singular  = r_sing;
    assign o_inv.saturated = r_sat;

    // a singular result carries an all-zero matrix
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_sing) |-> (r_res[0] == '0 && r_res[1] == '0 && r_res[2] == '0 &&
                                r_res[3] == '0 && r_res[4] == '0 && r_res[5] == '0 &&
                                r_res[6] == '0 && r_res[7] == '0 && r_res[8] == '0))
        else $error("singular result with nonzero element");

    // a stall freezes the front of the pipeline
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_ovld)
        else $error("result valid after reset");

endmodule

[design/m3inv_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_div
// Nine-lane pipelined restoring divider, one quotient bit per stage,
// shared divisor, rounded quotient with overflow flag per lane.
// ----------------------------------------------------------------------------
module m3inv_div #(
    parameter int W  = m3inv_pkg::ELEMENT_WIDTH_DEF,
    parameter int NW = 2 * m3inv_pkg::ELEMENT_WIDTH_DEF + 1 + 2 * m3inv_pkg::FRACTION_BITS_DEF,
    parameter int DW = 3 * m3inv_pkg::ELEMENT_WIDTH_DEF + 3,
    parameter int TW = 3 * m3inv_pkg::ELEMENT_WIDTH_DEF + 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [NW-1:0]                     i_num [m3inv_pkg::NUM_ELEM],
    input  logic [m3inv_pkg::NUM_ELEM-1:0]    i_neg,
    input  logic [DW-1:0]                     i_den,
    input  logic [TW-1:0]                     i_tag,
    output logic                              o_valid,
    output logic [W:0]                        o_quo [m3inv_pkg::NUM_ELEM],
    output m3inv_pkg::t_div_flags             o_flags,
    output logic [TW-1:0]                     o_tag
);
    import m3inv_pkg::*;

    localparam int XW = (NW + 1 > DW + W + 1) ? NW + 1 : DW + W + 1;

    logic [W+1:0]          r_vld;
    logic [NW-1:0]         r_rem [W+1][NUM_ELEM];
    logic [W-1:0]          r_quo [W+1][NUM_ELEM];
    logic [DW-1:0]         r_den [W+1];
    logic [TW-1:0]         r_tag [W+2];
    logic [NUM_ELEM-1:0]   r_ovf [W+2];
    logic [NUM_ELEM-1:0]   r_neg [W+2];
    logic [W:0]            r_oquo [NUM_ELEM];

    logic [XW-1:0]         w_sub [W][NUM_ELEM];
    logic [NUM_ELEM-1:0]   w_ge  [W];
    logic [NUM_ELEM-1:0]   w_ovf;
    logic [NUM_ELEM-1:0]   w_rnd;

    always_comb begin
        for (int l = 0; l < NUM_ELEM; l++) begin
            // quotient would need more than W bits
            w_ovf[l] = XW'(i_num[l]) >= (XW'(i_den) << W);
            w_rnd[l] = (XW'(r_rem[W][l]) << 1) >= XW'(r_den[W]);
        end
        for (int s = 0; s < W; s++) begin
            for (int l = 0; l < NUM_ELEM; l++) begin
                w_sub[s][l] = XW'(r_rem[s][l]) - (XW'(r_den[s]) << (W - 1 - s));
                w_ge[s][l]  = ~w_sub[s][l][XW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[W:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
            r_neg[0] <= i_neg;
            r_ovf[0] <= w_ovf;
            for (int l = 0; l < NUM_ELEM; l++) begin
                r_rem[0][l] <= i_num[l];
                r_quo[0][l] <= '0;
            end
            for (int s = 0; s < W; s++) begin
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
                for (int l = 0; l < NUM_ELEM; l++) begin
                    r_rem[s+1][l] <= w_ge[s][l] ? w_sub[s][l][NW-1:0] : r_rem[s][l];
                    r_quo[s+1][l] <= {r_quo[s][l][W-2:0], w_ge[s][l]};
                end
            end
            r_tag[W+1] <= r_tag[W];
            r_neg[W+1] <= r_neg[W];
            r_ovf[W+1] <= r_ovf[W];
            for (int l = 0; l < NUM_ELEM; l++) begin
                r_oquo[l] <= {1'b0, r_quo[W][l]} + (W+1)'(w_rnd[l]);
            end
        end
    end

    assign o_valid     = r_vld[W+1];
    assign o_quo       = r_oquo;
    assign o_flags.ovf = r_ovf[W+1];
    assign o_flags.neg = r_neg[W+1];
    assign o_tag       = r_tag[W+1];

endmodule
